// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rasterizer rtl
// depends on nothing; taken in by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/slr_pkg.sv =====
// shared types and sequencer codes for the slope-intercept line rasterizer
// no dependencies
`default_nettype none

package slr_pkg;

  // status returned by the slope divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic [1:0] state_t;

  localparam state_t ST_IDLE = 2'd0;
  localparam state_t ST_DIV  = 2'd1;
  localparam state_t ST_EMIT = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/slope_intercept_line_rasterizer.sv =====
// Line rasterizer: takes one segment (start_x, start_y, end_x, end_y) per request and returns
// |d_major|+1 points in fixed point with FRAC_BITS fraction bits, last_point marking the end.
// The major axis is x when |dx| >= |dy|. Minor values are start_minor plus i times the rounded
// slope, saturated to the output range. One segment is handled at a time: the request is taken,
// then the slope is computed in the bit-serial slope divider (skipped for a zero-length segment),
// then one point per cycle is returned while out_ready is high.
// Depends on slr_pkg, slr_div and assert_macros.svh.
`default_nettype none

module slope_intercept_line_rasterizer #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [COORD_BITS-1:0]         start_x,
  input  wire logic signed [COORD_BITS-1:0]         start_y,
  input  wire logic signed [COORD_BITS-1:0]         end_x,
  input  wire logic signed [COORD_BITS-1:0]         end_y,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [COORD_BITS+FRAC_BITS-1:0]    point_x,
  output logic signed [COORD_BITS+FRAC_BITS-1:0]    point_y,
  output logic                                      steep,
  output logic                                      last_point
);
  import slr_pkg::*;

  `include "assert_macros.svh"

  localparam int CW = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int OW = CW + F;
  localparam int AW = OW + 2;
  localparam int NW = CW + F + 2;

  state_t state;
  state_t state_next;

  logic                 steep_r;
  logic                 dir_neg;
  logic                 min_neg;
  logic signed [CW-1:0] maj;
  logic signed [AW-1:0] minacc;
  logic signed [F+1:0]  inc;
  logic [CW-1:0]        cnt;

  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic [CW:0]          adx;
  logic [CW:0]          ady;
  logic                 steep_w;
  logic [CW-1:0]        steps_w;
  logic [CW-1:0]        amin_w;
  logic signed [CW-1:0] maj0_w;
  logic signed [CW-1:0] min0_w;
  logic                 take;
  logic                 give;

  div_stat_t            div_stat;
  logic [F:0]           quo;
  logic [NW-1:0]        div_num;
  logic [CW:0]          div_den;

  logic [OW-1:0]        maj_fx;
  logic [OW-1:0]        min_sat;
  logic [AW-OW:0]       min_top;

  assign take = in_valid && in_ready;
  assign give = out_valid && out_ready;

  // segment setup, all from the request fields
  assign dx      = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
  assign dy      = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
  assign adx     = dx[CW] ? -dx : dx;
  assign ady     = dy[CW] ? -dy : dy;
  assign steep_w = ady > adx;
  assign steps_w = steep_w ? ady[CW-1:0] : adx[CW-1:0];
  assign amin_w  = steep_w ? adx[CW-1:0] : ady[CW-1:0];
  assign maj0_w  = steep_w ? start_y : start_x;
  assign min0_w  = steep_w ? start_x : start_y;

  // round to nearest: (2*|dmin|*2^F + |dmaj|) / (2*|dmaj|)
  assign div_num = {1'b0, amin_w, {(F+1){1'b0}}} + {{(NW-CW){1'b0}}, steps_w};
  assign div_den = {steps_w, 1'b0};

  slr_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(take && steps_w != '0),
    .num  (div_num),
    .den  (div_den),
    .stat (div_stat),
    .quo  (quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) state_next = (steps_w != '0) ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && cnt == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      steep_r <= steep_w;
      dir_neg <= steep_w ? dy[CW] : dx[CW];
      min_neg <= steep_w ? dx[CW] : dy[CW];
      maj     <= maj0_w;
      minacc  <= {{(AW-OW){min0_w[CW-1]}}, min0_w, {F{1'b0}}};
      cnt     <= steps_w;
      inc     <= '0;
    end else if (div_stat.done) begin
      // m * dir carries the sign of d_minor
      inc <= min_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end else if (give && cnt != '0) begin
      maj    <= maj + (dir_neg ? {CW{1'b1}} : CW'(1));
      minacc <= minacc + {{(AW-F-2){inc[F+1]}}, inc};
      cnt    <= cnt - 1'b1;
    end
  end

  assign maj_fx  = {maj, {F{1'b0}}};
  assign min_top = minacc[AW-1:OW-1];

  always_comb begin
    if ((&min_top) || !(|min_top)) begin
      min_sat = minacc[OW-1:0];
    end else if (minacc[AW-1]) begin
      min_sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      min_sat = {1'b0, {(OW-1){1'b1}}};
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_EMIT);
  assign point_x    = steep_r ? min_sat : maj_fx;
  assign point_y    = steep_r ? maj_fx : min_sat;
  assign steep      = steep_r;
  assign last_point = (cnt == '0);

  `ASSERT_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid),
                 "request taken while points still pending")
  `ASSERT_NEXT(a_busy_after_take, clk, rst, take, !in_ready,
               "ready stayed high after a request")
  `ASSERT_NEXT(a_idle_after_last, clk, rst, give && last_point, in_ready,
               "not ready after the final point")
  `ASSERT_IMPL(a_done_in_div, clk, rst, div_stat.done, state == ST_DIV,
               "slope finished outside the divide phase")

endmodule

`default_nettype wire

// ===== hdl/slr_div.sv =====
// bit-serial restoring divider for the rasterizer slope, one quotient bit per cycle
// depends on slr_pkg and assert_macros.svh
`default_nettype none

module slr_div #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [COORD_BITS+FRAC_BITS+1:0]    num,
  input  wire logic [COORD_BITS:0]                den,
  output slr_pkg::div_stat_t                      stat,
  output logic      [FRAC_BITS:0]                 quo
);
  import slr_pkg::*;

  `include "assert_macros.svh"

  localparam int NW   = COORD_BITS + FRAC_BITS + 2;
  localparam int DW   = COORD_BITS + 2;
  localparam int CNTW = $clog2(NW);
  localparam logic [FRAC_BITS:0] QMAX = {1'b1, {FRAC_BITS{1'b0}}};

  logic [DW-1:0]   rem;
  logic [NW-1:0]   qn;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;

  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic            ge;

  assign rem_sh = {rem, qn[NW-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = ~diff[DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      qn    <= num;
      den_r <= {{(DW-COORD_BITS-1){1'b0}}, den};
      cnt   <= CNTW'(NW - 1);
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      qn  <= {qn[NW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = qn[FRAC_BITS:0];

  `ASSERT_IMPL(a_div_no_restart, clk, rst, start, !busy, "divider started while busy")
  `ASSERT_IMPL(a_div_quo_range, clk, rst, done, quo <= QMAX, "slope magnitude above one")
  `ASSERT_IMPL(a_div_done_idle, clk, rst, done, !busy, "divider done while still busy")

endmodule

`default_nettype wire
